>>> sv/pas_pkg.sv
// Shared types, codes and constants of the polled ADC averaging sequencer.
`default_nettype none
package pas_pkg;

  localparam int TIMER_BITS  = 20;
  localparam int MAX_SAMPLES = 256;
  localparam int CNT_W       = 9;
  localparam int SUM_W       = 25;
  localparam int DEN_W       = 24;
  localparam int DVD_W       = 41;
  localparam int STEP_W      = 6;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  // Command codes of the input channel.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_RESP  = 2'd2;

  // Bus status codes.
  localparam logic [1:0] BUS_OK    = 2'd0;
  localparam logic [1:0] BUS_INTR  = 2'd1;
  localparam logic [1:0] BUS_FAIL  = 2'd2;
  localparam logic [1:0] BUS_SHORT = 2'd3;

  // Result kinds and error codes.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_MEAS  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] ERR_TIMEOUT = 2'd0;
  localparam logic [1:0] ERR_BUS     = 2'd1;
  localparam logic [1:0] ERR_SHORT   = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [3:0] REG_SETUP   = 4'd0;
  localparam logic [3:0] REG_POINTER = 4'd1;
  localparam logic [3:0] REG_COUNT   = 4'd2;
  localparam logic [3:0] REG_SCALE   = 4'd3;
  localparam logic [3:0] REG_OFFSET  = 4'd4;
  localparam logic [3:0] REG_WAIT    = 4'd5;
  localparam logic [3:0] REG_RETRY   = 4'd6;
  localparam logic [3:0] REG_TIMEOUT = 4'd7;

  localparam logic [CNT_W-1:0]      COUNT_RST = 9'd1;
  localparam logic signed [31:0]    SCALE_RST = 32'sd65536;
  localparam logic [TIMER_BITS-1:0] WAIT_RST  = 20'd1000;
  localparam logic [TIMER_BITS-1:0] POLL_RST  = 20'd200;

  // Reciprocal of five, scaled by 2^22; exact floor for 20-bit operands.
  localparam logic [19:0] RECIP5    = 20'd838861;
  localparam logic [19:0] POLL_MIN  = 20'd10;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SETUP, PH_WAIT, PH_POLL, PH_PTR, PH_DATA
  } phase_t;

  typedef enum logic [0:0] {
    S_RUN, S_CALC
  } ctl_st_t;

  typedef enum logic [2:0] {
    A_IDLE, A_DIV, A_CLAMP, A_MUL, A_ABS, A_RND, A_ADD, A_SAT
  } arith_st_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic signed [31:0]      scale;
    logic signed [31:0]      offset;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] result;
  } arith_rsp_t;

  // Re-poll interval: max(wait / 5, 10).
  function automatic logic [TIMER_BITS-1:0] poll_wait(input logic [TIMER_BITS-1:0] w);
    logic [39:0] prod;
    logic [19:0] q;
    prod = w * RECIP5;
    q    = {2'b00, prod[39:22]};
    return (q > POLL_MIN) ? q : POLL_MIN;
  endfunction

endpackage
`default_nettype wire

>>> sv/pas_if.sv
// Channel interfaces: input events, bus requests and results, configuration writes.
`default_nettype none
interface pas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  bus_status;
  logic [15:0] bus_data;
  modport source (output valid, cmd, bus_status, bus_data, input ready);
  modport sink   (input valid, cmd, bus_status, bus_data, output ready);
endinterface

interface pas_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         byte_count;
  logic [23:0]        write_payload;
  logic signed [31:0] measurement;
  logic [1:0]         error_code;
  modport source (output valid, kind, byte_count, write_payload, measurement, error_code,
                  input ready);
  modport sink   (input valid, kind, byte_count, write_payload, measurement, error_code,
                  output ready);
endinterface

interface pas_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/pas_arith.sv
// Iterative unit: rounding divide, clamp, Q16.16 scale and saturating offset.
`default_nettype none
module pas_arith import pas_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  arith_req_t  req,
  output arith_rsp_t  rsp
);

  arith_st_t st_r, st_nxt;

  logic                    neg_r;
  logic [DVD_W-1:0]        dvd_r;
  logic [DEN_W-1:0]        den_r;
  logic [DEN_W-1:0]        rem_r;
  logic [DVD_W-1:0]        quo_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [31:0]      scale_r;
  logic signed [31:0]      off_r;
  logic signed [31:0]      avg_r;
  logic signed [63:0]      prod_r;
  logic                    pneg_r;
  logic [63:0]             pmag_r;
  logic [47:0]             qr_r;
  logic signed [49:0]      acc_r;
  logic signed [31:0]      res_r;
  logic                    done_r;

  logic [SUM_W-1:0]  mag;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem_sh;
  logic              ge;
  logic signed [31:0] q_s;
  logic signed [49:0] qr_s;

  always_comb begin
    mag    = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
    den    = {req.cnt, 15'd0} - {15'd0, req.cnt};
    rem_sh = {rem_r[DEN_W-2:0], dvd_r[DVD_W-1]};
    ge     = rem_sh >= den_r;
    q_s    = neg_r ? -$signed({13'd0, quo_r[18:0]}) : $signed({13'd0, quo_r[18:0]});
    qr_s   = pneg_r ? -$signed({2'b00, qr_r}) : $signed({2'b00, qr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      A_IDLE:  if (req.start) st_nxt = A_DIV;
      A_DIV:   if (step_r == STEP_W'(DVD_W - 1)) st_nxt = A_CLAMP;
      A_CLAMP: st_nxt = A_MUL;
      A_MUL:   st_nxt = A_ABS;
      A_ABS:   st_nxt = A_RND;
      A_RND:   st_nxt = A_ADD;
      A_ADD:   st_nxt = A_SAT;
      A_SAT:   st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == A_SAT);
    end
  end

  // One quotient bit per cycle; the divisor is n * 32767 and half of it
  // is pre-added so the quotient comes out rounded to nearest.
  always_ff @(posedge clk) begin
    unique case (st_r)
      A_IDLE: begin
        neg_r   <= req.sum[SUM_W-1];
        den_r   <= den;
        dvd_r   <= {mag, 16'd0} + {17'd0, den[DEN_W-1:1]};
        rem_r   <= '0;
        quo_r   <= '0;
        step_r  <= '0;
        scale_r <= req.scale;
        off_r   <= req.offset;
      end
      A_DIV: begin
        rem_r  <= ge ? rem_sh - den_r : rem_sh;
        quo_r  <= {quo_r[DVD_W-2:0], ge};
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
        step_r <= step_r + STEP_W'(1);
      end
      A_CLAMP: avg_r <= (q_s < off_r) ? off_r : q_s;
      A_MUL:   prod_r <= scale_r * avg_r;
      A_ABS: begin
        pneg_r <= prod_r[63];
        pmag_r <= prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
      end
      A_RND:   qr_r <= 48'((pmag_r + 64'd32768) >> 16);
      A_ADD:   acc_r <= qr_s + 50'(off_r);
      A_SAT: begin
        if (acc_r > 50'sd2147483647) begin
          res_r <= 32'sh7FFFFFFF;
        end else if (acc_r < -50'sd2147483648) begin
          res_r <= 32'sh80000000;
        end else begin
          res_r <= acc_r[31:0];
        end
      end
      default: ;
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == A_DIV |-> rem_r < den_r) else $error("partial remainder not below divisor");
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == A_CLAMP |-> quo_r[DVD_W-1:19] == '0) else $error("average out of range");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> st_r == A_IDLE) else $error("start while unit busy");

endmodule
`default_nettype wire

>>> sv/polled_adc_averaging_sequencer.sv
// Top level: event-driven ADC polling sequencer with result averaging.
// Usage:
//  in_ch carries events: start, one-microsecond tick, or a bus response with
//  status and data. out_ch carries at most one result per event: a bus write
//  request, a bus read request, a finished measurement or an error.
//  cfg_ch writes the eight setup registers; it is always ready and must only
//  be used while no measurement is in progress.
// Timing:
//  When an ordinary event is taken, its result, if any, is shown in the
//  output register on the next cycle, so one event per cycle is taken while
//  results are drained. The response that completes the last sample starts
//  the divide/scale unit, and the measurement reaches the output register
//  after 41 divide steps, then clamp, multiply, magnitude, round, offset and
//  saturate, and a last step into the output register. in_ch is not ready
//  during that time.
//  A new event is taken while the previous result is being transferred.
// Reset: returns to idle with an empty output register and all setup
//  registers at their defaults.
// Stall: while a result waits on out_ch, in_ch is held not ready.
`default_nettype none
module polled_adc_averaging_sequencer import pas_pkg::*; (
  input wire         clk,
  input wire         rst_n,
  pas_in_if.sink     in_ch,
  pas_out_if.source  out_ch,
  pas_cfg_if.sink    cfg_ch
);

  logic [23:0]            setup_r;
  logic [7:0]             pointer_r;
  logic [CNT_W-1:0]       count_r;
  logic signed [31:0]     scale_r;
  logic signed [31:0]     offset_r;
  logic [TIMER_BITS-1:0]  wait_r;
  logic [TIMER_BITS-1:0]  poll_r;
  logic [TIMER_BITS-1:0]  retry_r;
  logic [TIMER_BITS-1:0]  timeout_r;

  ctl_st_t                ctl_r, ctl_nxt;
  phase_t                 ph_r, ph_nxt;
  logic [TIMER_BITS-1:0]  el_r, el_nxt;
  logic [TIMER_BITS-1:0]  wr_r, wr_nxt;
  logic [CNT_W-1:0]       dc_r, dc_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  logic                   out_valid_r;
  logic [1:0]             kind_r;
  logic [1:0]             cnt_r;
  logic [23:0]            pay_r;
  logic signed [31:0]     meas_r;
  logic [1:0]             err_r;

  logic                   in_acc;
  logic                   emit;
  logic                   go_calc;
  logic [1:0]             o_kind;
  logic [1:0]             o_cnt;
  logic [23:0]            o_pay;
  logic [1:0]             o_err;
  logic                   timed_out;
  logic [TIMER_BITS-1:0]  el_inc;
  logic [TIMER_BITS-1:0]  wr_dec;
  logic signed [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0]       dc_inc;
  logic [CNT_W-1:0]       eff_n;

  arith_req_t             areq;
  arith_rsp_t             arsp;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (ctl_r == S_RUN) && (!out_valid_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r   <= '0;
      pointer_r <= '0;
      count_r   <= COUNT_RST;
      scale_r   <= SCALE_RST;
      offset_r  <= '0;
      wait_r    <= WAIT_RST;
      poll_r    <= POLL_RST;
      retry_r   <= '0;
      timeout_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SETUP:   setup_r   <= cfg_ch.data[23:0];
        REG_POINTER: pointer_r <= cfg_ch.data[7:0];
        REG_COUNT:   count_r   <= cfg_ch.data[CNT_W-1:0];
        REG_SCALE:   scale_r   <= cfg_ch.data;
        REG_OFFSET:  offset_r  <= cfg_ch.data;
        REG_WAIT: begin
          wait_r <= cfg_ch.data[TIMER_BITS-1:0];
          poll_r <= poll_wait(cfg_ch.data[TIMER_BITS-1:0]);
        end
        REG_RETRY:   retry_r   <= cfg_ch.data[TIMER_BITS-1:0];
        REG_TIMEOUT: timeout_r <= cfg_ch.data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (count_r > CNT_W'(MAX_SAMPLES)) begin
      eff_n = CNT_W'(MAX_SAMPLES);
    end else begin
      eff_n = count_r;
    end
  end

  always_comb begin
    ph_nxt    = ph_r;
    el_nxt    = el_r;
    wr_nxt    = wr_r;
    dc_nxt    = dc_r;
    sum_nxt   = sum_r;
    ctl_nxt   = ctl_r;
    emit      = 1'b0;
    go_calc   = 1'b0;
    o_kind    = KIND_WRITE;
    o_cnt     = 2'd0;
    o_pay     = '0;
    o_err     = ERR_TIMEOUT;
    timed_out = el_r > timeout_r;
    el_inc    = (el_r == TMAX) ? el_r : el_r + TIMER_BITS'(1);
    wr_dec    = (wr_r != '0) ? wr_r - TIMER_BITS'(1) : wr_r;
    sum_add   = sum_r + SUM_W'($signed(in_ch.bus_data));
    dc_inc    = dc_r + CNT_W'(1);

    if (ctl_r == S_CALC) begin
      if (arsp.done) ctl_nxt = S_RUN;
    end else if (in_acc) begin
      unique case (in_ch.cmd)
        CMD_START: begin
          if (ph_r == PH_IDLE) begin
            el_nxt  = '0;
            dc_nxt  = '0;
            sum_nxt = '0;
            ph_nxt  = PH_SETUP;
            emit    = 1'b1;
            o_cnt   = 2'd3;
            o_pay   = setup_r;
          end
        end
        CMD_TICK: begin
          if (ph_r != PH_IDLE) begin
            el_nxt = el_inc;
            if (ph_r == PH_WAIT) begin
              wr_nxt = wr_dec;
              if (wr_dec == '0) begin
                ph_nxt = PH_POLL;
                emit   = 1'b1;
                o_kind = KIND_READ;
                o_cnt  = 2'd1;
              end
            end
          end
        end
        CMD_RESP: begin
          if (ph_r != PH_IDLE && ph_r != PH_WAIT) begin
            unique case (in_ch.bus_status)
              BUS_INTR: begin
                emit = 1'b1;
                if (timed_out) begin
                  ph_nxt = PH_IDLE;
                  o_kind = KIND_ERR;
                  o_err  = ERR_TIMEOUT;
                end else begin
                  ph_nxt = PH_SETUP;
                  o_cnt  = 2'd3;
                  o_pay  = setup_r;
                end
              end
              BUS_FAIL, BUS_SHORT: begin
                emit   = 1'b1;
                ph_nxt = PH_IDLE;
                o_kind = KIND_ERR;
                o_err  = (in_ch.bus_status == BUS_FAIL) ? ERR_BUS : ERR_SHORT;
              end
              default: begin
                unique case (ph_r)
                  PH_SETUP: begin
                    // A zero wait asks for the status byte right away.
                    if (wait_r == '0) begin
                      ph_nxt = PH_POLL;
                      emit   = 1'b1;
                      o_kind = KIND_READ;
                      o_cnt  = 2'd1;
                    end else begin
                      ph_nxt = PH_WAIT;
                      wr_nxt = wait_r;
                    end
                  end
                  PH_POLL: begin
                    if (in_ch.bus_data[7]) begin
                      ph_nxt = PH_PTR;
                      emit   = 1'b1;
                      o_cnt  = 2'd1;
                      o_pay  = {16'd0, pointer_r};
                    end else if (timed_out) begin
                      ph_nxt = PH_IDLE;
                      emit   = 1'b1;
                      o_kind = KIND_ERR;
                      o_err  = ERR_TIMEOUT;
                    end else if (el_r > retry_r) begin
                      ph_nxt = PH_SETUP;
                      emit   = 1'b1;
                      o_cnt  = 2'd3;
                      o_pay  = setup_r;
                    end else begin
                      ph_nxt = PH_WAIT;
                      wr_nxt = poll_r;
                    end
                  end
                  PH_PTR: begin
                    ph_nxt = PH_DATA;
                    emit   = 1'b1;
                    o_kind = KIND_READ;
                    o_cnt  = 2'd2;
                  end
                  PH_DATA: begin
                    sum_nxt = sum_add;
                    dc_nxt  = dc_inc;
                    if (dc_inc >= eff_n) begin
                      ph_nxt  = PH_IDLE;
                      go_calc = 1'b1;
                      ctl_nxt = S_CALC;
                    end else begin
                      el_nxt = '0;
                      ph_nxt = PH_SETUP;
                      emit   = 1'b1;
                      o_cnt  = 2'd3;
                      o_pay  = setup_r;
                    end
                  end
                  default: ;
                endcase
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= S_RUN;
      ph_r  <= PH_IDLE;
      el_r  <= '0;
      wr_r  <= '0;
      dc_r  <= '0;
      sum_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
      ph_r  <= ph_nxt;
      el_r  <= el_nxt;
      wr_r  <= wr_nxt;
      dc_r  <= dc_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit || arsp.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= o_kind;
      cnt_r  <= o_cnt;
      pay_r  <= o_pay;
      meas_r <= '0;
      err_r  <= o_err;
    end else if (arsp.done) begin
      kind_r <= KIND_MEAS;
      cnt_r  <= 2'd0;
      pay_r  <= '0;
      meas_r <= arsp.result;
      err_r  <= ERR_TIMEOUT;
    end
  end

  assign areq.start  = go_calc;
  assign areq.sum    = sum_add;
  assign areq.cnt    = eff_n;
  assign areq.scale  = scale_r;
  assign areq.offset = offset_r;

  pas_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.byte_count    = cnt_r;
  assign out_ch.write_payload = pay_r;
  assign out_ch.measurement   = meas_r;
  assign out_ch.error_code    = err_r;

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    arsp.done |-> ctl_r == S_CALC) else $error("measurement without pending calculation");
  a_calc_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == S_CALC |-> !in_ch.ready) else $error("event taken during calculation");
  a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == PH_WAIT |-> wr_r != '0) else $error("waiting with zero ticks left");
  a_calc_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    go_calc |=> !out_valid_r) else $error("result register busy at calculation start");

endmodule
`default_nettype wire
